[src/sdh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sdh_pkg;
  localparam logic [63:0] K_SM1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] K_SM2 = 64'h94d049bb133111eb;
  localparam logic [63:0] K_SM3 = 64'hC13FA9A902A6328F;
  localparam logic [63:0] K_PX  = 64'h4C957F2D8A1E6B3C;
  localparam logic [63:0] K_M1  = 64'h7297352743776A1B;
  localparam logic [63:0] K_PY  = 64'hD3E99E3B6C1A4F78;
  localparam logic [63:0] K_M2  = 64'h6955927086495225;
  localparam logic [63:0] K_PZ  = 64'h8F142FC07892A5B6;
  localparam logic [63:0] K_M3  = 64'h91E10DA5C79E7B1D;
  localparam logic [63:0] K_PHI = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] K_IV  = 64'h6A09E667F3BCC908;
  localparam int DIGIT_W = 4;
  localparam int MUL_STEPS = 64 / DIGIT_W;
endpackage
`default_nettype wire

[src/sdh_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface sdh_in_if;
  logic valid;
  logic ready;
  logic [7:0] seed_byte;
  logic [15:0] message_length;
  logic first_byte;
  logic last_byte;
  modport source (output valid, seed_byte, message_length, first_byte, last_byte, input ready);
  modport sink (input valid, seed_byte, message_length, first_byte, last_byte, output ready);
endinterface

interface sdh_out_if;
  logic valid;
  logic ready;
  logic [63:0] digest;
  modport source (output valid, digest, input ready);
  modport sink (input valid, digest, output ready);
endinterface
`default_nettype wire

[src/sdh_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// 64x64 low-half multiply, one 4-bit digit of the multiplier per cycle
module sdh_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      p
);
  import sdh_pkg::*;
  localparam int CW = $clog2(MUL_STEPS);
  logic [63:0] mcand;
  logic [63:0] mplier;
  logic [CW-1:0] cnt;
  logic busy;
  logic [63:0] part;

  assign part = mcand * {{(64-DIGIT_W){1'b0}}, mplier[DIGIT_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      mplier <= b;
      p      <= '0;
    end else if (busy) begin
      p      <= p + part;
      mcand  <= mcand << DIGIT_W;
      mplier <= mplier >> DIGIT_W;
    end
  end
endmodule
`default_nettype wire

[src/seed_digest_hash64.sv]
`timescale 1ns / 1ps
`default_nettype none
// seed digest: folds a byte message into one 64-bit value
// input channel in: one request per message byte with seed_byte, message_length,
//   first_byte (open from length) and last_byte (close and emit)
// output channel out: one digest request after each byte marked last
// every multiply runs on one shared digit-serial unit, 4 bits per cycle, with
//   operand setup before it and write-back after it
// a byte costs 9 multiplies plus the fold, xorshift and finish steps; a first
//   byte adds 3 multiplies for the opening mix, a last byte 3 more for the
//   closing mix and the hand-over
// one byte is in work at a time; in.ready is high only in idle
// a finished digest sits in the output register; the next byte is taken
//   while it waits, but a new digest waits until the old one is taken
// reset (rst, synchronous) clears the running hash to zero and the output valid
module seed_digest_hash64 (
  input wire logic clk,
  input wire logic rst,
  sdh_in_if.sink   in,
  sdh_out_if.source out
);
  import sdh_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_WAIT = 6'b000100,
    S_STEP = 6'b001000,
    S_OUT  = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

  // micro-op sequence: index into program
  typedef enum logic [4:0] {
    P_OPEN0, P_OPEN1, P_OPEN2, P_OPEN3,
    P_FOLD,
    P_F0, P_F1, P_F2, P_F3,
    P_X1, P_M1, P_Y1, P_M2, P_Z1, P_M3, P_FIN,
    P_C0, P_C1, P_C2, P_C3,
    P_DONE
  } op_t;

  state_t state;
  op_t op;
  logic [63:0] hash;
  logic [63:0] v;
  logic [15:0] len;
  logic [7:0] byte_q;
  logic last_q;
  logic mul_start, mul_done;
  logic [63:0] mul_a, mul_b, mul_p;
  logic [63:0] fold;
  logic [63:0] v_next;
  op_t op_next;
  logic need_mul;

  sdh_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  assign fold = hash ^ ({56'd0, byte_q} + K_PHI + (hash << 6) + (hash >> 2));
  assign in.ready = (state == S_IDLE);

  // per op: operand setup (pre-multiply xorshift or shift) and which constant
  always_comb begin
    mul_a = v;
    mul_b = K_SM1;
    need_mul = 1'b1;
    unique case (op)
      P_OPEN0, P_F0, P_C0: begin mul_a = v ^ (v >> 30); mul_b = K_SM1; end
      P_OPEN1, P_F1, P_C1: begin mul_a = v ^ (v >> 27); mul_b = K_SM2; end
      P_OPEN2, P_F2, P_C2: begin mul_a = v ^ (v >> 31); mul_b = K_SM3; end
      P_X1: begin mul_a = v >> 12; mul_b = K_PX; end
      P_M1: begin mul_a = v; mul_b = K_M1; end
      P_Y1: begin mul_a = v >> 25; mul_b = K_PY; end
      P_M2: begin mul_a = v; mul_b = K_M2; end
      P_Z1: begin mul_a = v >> 27; mul_b = K_PZ; end
      P_M3: begin mul_a = v; mul_b = K_M3; end
      default: need_mul = 1'b0;
    endcase
  end

  // result of a finished multiply, and next op
  always_comb begin
    v_next = mul_p;
    op_next = op;
    unique case (op)
      P_OPEN0: op_next = P_OPEN1;
      P_OPEN1: op_next = P_OPEN2;
      P_OPEN2: op_next = P_OPEN3;
      P_F0: op_next = P_F1;
      P_F1: op_next = P_F2;
      P_F2: op_next = P_F3;
      P_X1: begin v_next = v ^ mul_p; op_next = P_M1; end
      P_M1: op_next = P_Y1;
      P_Y1: begin v_next = v ^ mul_p; op_next = P_M2; end
      P_M2: op_next = P_Z1;
      P_Z1: begin v_next = v ^ mul_p; op_next = P_M3; end
      P_M3: op_next = P_FIN;
      P_C0: op_next = P_C1;
      P_C1: op_next = P_C2;
      P_C2: op_next = P_C3;
      default: op_next = op;
    endcase
  end

  assign mul_start = (state == S_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hash <= '0;
      out.valid <= 1'b0;
      op <= P_FOLD;
    end else begin
      if (out.valid && out.ready) out.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in.valid) begin
          byte_q <= in.seed_byte;
          len <= in.message_length;
          last_q <= in.last_byte;
          if (in.first_byte) begin
            v <= {48'd0, in.message_length} + K_PHI;
            op <= P_OPEN0;
            state <= S_MUL;
          end else begin
            op <= P_FOLD;
            state <= S_STEP;
          end
        end
        S_MUL: state <= S_WAIT;
        S_WAIT: if (mul_done) begin
          v <= v_next;
          op <= op_next;
          state <= S_STEP;
        end
        S_STEP: begin
          if (need_mul) state <= S_MUL;
          else begin
            unique case (op)
              P_OPEN3: begin
                hash <= K_IV ^ (v ^ (v >> 29));
                op <= P_FOLD;
              end
              P_FOLD: begin
                v <= fold;
                op <= P_F0;
              end
              P_F3: begin
                v <= v ^ (v >> 29);
                op <= P_X1;
              end
              P_FIN: begin
                hash <= v ^ (v >> 13);
                v <= {48'd0, len};
                if (last_q) op <= P_C0;
                else state <= S_IDLE;
              end
              P_C3: begin
                v <= hash ^ (v ^ (v >> 29));
                state <= S_HOLD;
                op <= P_DONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_HOLD: if (!out.valid || out.ready) state <= S_OUT;
        S_OUT: begin
          out.valid <= 1'b1;
          out.digest <= v;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a request is only taken when no byte is in work
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> (state == S_IDLE)) else $error("ready outside idle");
  // a new digest never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> $stable(out.digest)) else $error("digest lost");
  // the multiplier never signals done right after a start
  a_mul_start: assert property (@(posedge clk) disable iff (rst)
    mul_start |=> !mul_done) else $error("mul restart");
`endif
endmodule
`default_nettype wire
